[hdl/sab_pkg.sv]
// Shared types, constants and the channel blend function for the sprite alpha blitter.
// Used by the channel interfaces, the register block and the top level. No dependencies.
package sab_pkg;

  localparam int ADDR_W     = 16;
  localparam int PIX_W      = 32;
  localparam int DIM_W      = 9;
  localparam int HALF_W     = 8;
  localparam int POS_W      = 11;
  localparam int SPR_W      = 8;
  localparam int CMD_W      = 2;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam int DEF_MAX_CANVAS_WIDTH  = 256;
  localparam int DEF_MAX_CANVAS_HEIGHT = 256;
  localparam int DEF_MAX_SPRITE_HALF   = 128;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BLEND = 2'd2;

  localparam logic [2:0] REG_CANVAS_WIDTH  = 3'd0;
  localparam logic [2:0] REG_CANVAS_HEIGHT = 3'd1;
  localparam logic [2:0] REG_HALF_WIDTH    = 3'd2;
  localparam logic [2:0] REG_HALF_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_CENTER_X      = 3'd4;
  localparam logic [2:0] REG_CENTER_Y      = 3'd5;

  localparam logic [DIM_W-1:0]  RST_CANVAS_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0]  RST_CANVAS_HEIGHT = 9'd256;
  localparam logic [HALF_W-1:0] RST_HALF_WIDTH    = 8'd70;
  localparam logic [HALF_W-1:0] RST_HALF_HEIGHT   = 8'd28;

  typedef struct packed {
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
    logic [HALF_W-1:0] sprite_half_width;
    logic [HALF_W-1:0] sprite_half_height;
    logic [POS_W-1:0]  sprite_center_x;
    logic [POS_W-1:0]  sprite_center_y;
  } sab_cfg_t;

  // (s*a + d*(255-a)) / 255, truncated. The sum is at most 65025, where
  // (m + (m >> 8) + 1) >> 8 equals m / 255 exactly.
  function automatic logic [7:0] mix_chan(logic [7:0] s, logic [7:0] d, logic [7:0] a);
    logic [15:0] m;
    logic [15:0] q;
    m = ({8'd0, s} * {8'd0, a}) + ({8'd0, d} * {8'd0, 8'hFF - a});
    q = m + (m >> 8) + 16'd1;
    return q[15:8];
  endfunction

endpackage

[hdl/sab_if.sv]
// Request and response channel interfaces of the sprite alpha blitter.
// Depends on sab_pkg for the field widths.
interface sab_req_if import sab_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] canvas_addr;
  logic [SPR_W-1:0]  sprite_col;
  logic [SPR_W-1:0]  sprite_row;
  logic [PIX_W-1:0]  pixel_in;

  modport source (output valid, command, canvas_addr, sprite_col, sprite_row, pixel_in,
                  input ready);
  modport sink (input valid, command, canvas_addr, sprite_col, sprite_row, pixel_in,
                output ready);
endinterface

interface sab_rsp_if import sab_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_out;
  logic              wrote_canvas;
  logic [ADDR_W-1:0] target_addr;

  modport source (output valid, pixel_out, wrote_canvas, target_addr, input ready);
  modport sink (input valid, pixel_out, wrote_canvas, target_addr, output ready);
endinterface

[hdl/sab_apb_regs.sv]
// APB configuration registers of the sprite alpha blitter: canvas size, sprite
// half size and sprite center. Depends on sab_pkg.
module sab_apb_regs import sab_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output sab_cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width        <= RST_CANVAS_WIDTH;
      cfg.frame_height       <= RST_CANVAS_HEIGHT;
      cfg.sprite_half_width  <= RST_HALF_WIDTH;
      cfg.sprite_half_height <= RST_HALF_HEIGHT;
      cfg.sprite_center_x    <= '0;
      cfg.sprite_center_y    <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CANVAS_WIDTH:  cfg.frame_width        <= pwdata[DIM_W-1:0];
        REG_CANVAS_HEIGHT: cfg.frame_height       <= pwdata[DIM_W-1:0];
        REG_HALF_WIDTH:    cfg.sprite_half_width  <= pwdata[HALF_W-1:0];
        REG_HALF_HEIGHT:   cfg.sprite_half_height <= pwdata[HALF_W-1:0];
        REG_CENTER_X:      cfg.sprite_center_x    <= pwdata[POS_W-1:0];
        REG_CENTER_Y:      cfg.sprite_center_y    <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CANVAS_WIDTH:  prdata = {{(APB_DATA_W-DIM_W){1'b0}}, cfg.frame_width};
      REG_CANVAS_HEIGHT: prdata = {{(APB_DATA_W-DIM_W){1'b0}}, cfg.frame_height};
      REG_HALF_WIDTH:    prdata = {{(APB_DATA_W-HALF_W){1'b0}}, cfg.sprite_half_width};
      REG_HALF_HEIGHT:   prdata = {{(APB_DATA_W-HALF_W){1'b0}}, cfg.sprite_half_height};
      REG_CENTER_X:      prdata = {{(APB_DATA_W-POS_W){1'b0}}, cfg.sprite_center_x};
      REG_CENTER_Y:      prdata = {{(APB_DATA_W-POS_W){1'b0}}, cfg.sprite_center_y};
      default:           prdata = '0;
    endcase
  end

endmodule

[hdl/sprite_alpha_blit_core.sv]
// Sprite alpha blitter: ARGB8888 canvas memory with write, read and alpha-blend requests.
// Each request passes stage 1, stage 2 and the output register. Throughput: one request
// per cycle while the output is empty or taken, set by the canvas memory taking one read
// and one write per cycle; a read or blend of the word written just before is forwarded.
// Reset clears the pipeline and restores register defaults; canvas words hold no
// defined value until written. Depends on sab_pkg, sab_if and sab_apb_regs.
module sprite_alpha_blit_core import sab_pkg::*; #(
  parameter int MAX_CANVAS_WIDTH  = DEF_MAX_CANVAS_WIDTH,
  parameter int MAX_CANVAS_HEIGHT = DEF_MAX_CANVAS_HEIGHT,
  parameter int MAX_SPRITE_HALF   = DEF_MAX_SPRITE_HALF
) (
  input  logic                  clk,
  input  logic                  rst,
  sab_req_if.sink               req,
  sab_rsp_if.source             rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int          DEPTH = 1 << ADDR_W;
  localparam logic [10:0] MAX_W = 11'(MAX_CANVAS_WIDTH);
  localparam logic [10:0] MAX_H = 11'(MAX_CANVAS_HEIGHT);
  localparam logic [9:0]  MAX_S = 10'(MAX_SPRITE_HALF);

  sab_cfg_t cfg;

  sab_apb_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  // Effective sizes with out-of-range register values saturated.
  logic [DIM_W-1:0]  cw, ch;
  logic [HALF_W-1:0] hw, hh;

  always_comb begin
    if (cfg.frame_width == '0)                  cw = 9'd1;
    else if ({2'b0, cfg.frame_width} > MAX_W)   cw = MAX_W[DIM_W-1:0];
    else                                        cw = cfg.frame_width;
    if (cfg.frame_height == '0)                 ch = 9'd1;
    else if ({2'b0, cfg.frame_height} > MAX_H)  ch = MAX_H[DIM_W-1:0];
    else                                        ch = cfg.frame_height;
    if (cfg.sprite_half_width == '0)                 hw = 8'd1;
    else if ({2'b0, cfg.sprite_half_width} > MAX_S)  hw = MAX_S[HALF_W-1:0];
    else                                             hw = cfg.sprite_half_width;
    if (cfg.sprite_half_height == '0)                hh = 8'd1;
    else if ({2'b0, cfg.sprite_half_height} > MAX_S) hh = MAX_S[HALF_W-1:0];
    else                                             hh = cfg.sprite_half_height;
  end

  logic adv;
  logic out_valid;

  assign adv       = !out_valid || rsp.ready;
  assign req.ready = adv;

  // Placement and bounds check on the incoming request.
  logic [11:0] xp, yp;
  logic        in_sprite, on_canvas;

  always_comb begin
    xp = {cfg.sprite_center_x[POS_W-1], cfg.sprite_center_x} - {4'b0, hw}
         + {4'b0, req.sprite_col};
    yp = {cfg.sprite_center_y[POS_W-1], cfg.sprite_center_y} - {4'b0, hh}
         + {4'b0, req.sprite_row};
    in_sprite = ({1'b0, req.sprite_col} < {hw, 1'b0}) &&
                ({1'b0, req.sprite_row} < {hh, 1'b0});
    on_canvas = !xp[11] && !yp[11] && (xp < {3'b0, cw}) && (yp < {3'b0, ch});
  end

  // Stage 1: address generation and memory read.
  logic              s1_valid;
  logic [CMD_W-1:0]  s1_cmd;
  logic [ADDR_W-1:0] s1_addr;
  logic [PIX_W-1:0]  s1_pix;
  logic              s1_ok;
  logic [DIM_W-1:0]  s1_x, s1_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd  <= req.command;
      s1_addr <= req.canvas_addr;
      s1_pix  <= req.pixel_in;
      s1_ok   <= in_sprite && on_canvas;
      s1_x    <= xp[DIM_W-1:0];
      s1_y    <= yp[DIM_W-1:0];
    end
  end

  logic [2*DIM_W-1:0] row_base;
  logic [ADDR_W-1:0]  s1_raddr;

  always_comb begin
    row_base = {{DIM_W{1'b0}}, s1_y} * {{DIM_W{1'b0}}, cw};
    if (s1_cmd == CMD_BLEND) begin
      s1_raddr = {{(ADDR_W-DIM_W){1'b0}}, s1_x} + row_base[ADDR_W-1:0];
    end else begin
      s1_raddr = s1_addr;
    end
  end

  // Stage 2: blend and write back.
  logic              s2_valid;
  logic [CMD_W-1:0]  s2_cmd;
  logic [ADDR_W-1:0] s2_addr;
  logic [PIX_W-1:0]  s2_pix;
  logic              s2_ok;
  logic [PIX_W-1:0]  rdata;
  logic              fwd_hit;
  logic [PIX_W-1:0]  fwd_data;

  logic [PIX_W-1:0]  canvas_mem [DEPTH];

  logic [PIX_W-1:0]  s2_old, s2_mix;
  logic              s2_we;
  logic [PIX_W-1:0]  s2_wdata;
  logic [PIX_W-1:0]  res_pixel;
  logic              res_wrote;
  logic [ADDR_W-1:0] res_addr;

  always_comb begin
    s2_old = fwd_hit ? fwd_data : rdata;
    s2_mix = {s2_old[31:24],
              mix_chan(s2_pix[23:16], s2_old[23:16], s2_pix[31:24]),
              mix_chan(s2_pix[15:8],  s2_old[15:8],  s2_pix[31:24]),
              mix_chan(s2_pix[7:0],   s2_old[7:0],   s2_pix[31:24])};
    res_pixel = '0;
    res_wrote = 1'b0;
    res_addr  = '0;
    s2_wdata  = s2_pix;
    case (s2_cmd)
      CMD_WRITE: begin
        res_pixel = s2_pix;
        res_wrote = 1'b1;
        res_addr  = s2_addr;
      end
      CMD_READ: begin
        res_pixel = s2_old;
        res_addr  = s2_addr;
      end
      CMD_BLEND: begin
        s2_wdata = s2_mix;
        if (s2_ok) begin
          res_pixel = s2_mix;
          res_wrote = 1'b1;
          res_addr  = s2_addr;
        end
      end
      default: ;
    endcase
    s2_we = s2_valid && res_wrote;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s2_we) begin
        canvas_mem[s2_addr] <= s2_wdata;
      end
      rdata <= canvas_mem[s1_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
      // The read above misses the write of the same edge, so that word is carried over.
      fwd_hit  <= s2_we && (s1_raddr == s2_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cmd   <= s1_cmd;
      s2_addr  <= s1_raddr;
      s2_pix   <= s1_pix;
      s2_ok    <= s1_ok;
      fwd_data <= s2_wdata;
    end
  end

  // Output register.
  logic [PIX_W-1:0]  out_pixel;
  logic              out_wrote;
  logic [ADDR_W-1:0] out_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel <= res_pixel;
      out_wrote <= res_wrote;
      out_addr  <= res_addr;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.pixel_out    = out_pixel;
  assign rsp.wrote_canvas = out_wrote;
  assign rsp.target_addr  = out_addr;

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> s1_valid)
    else $error("accepted request did not enter the pipeline");

  a_stage2_to_out: assert property (@(posedge clk) disable iff (rst)
    (adv && s2_valid) |=> out_valid)
    else $error("stage 2 request did not reach the output register");

  a_forward: assert property (@(posedge clk) disable iff (rst)
    (adv && s2_we && (s1_raddr == s2_addr)) |=> fwd_hit)
    else $error("read after write to the same canvas word was not forwarded");

  a_off_canvas_zero: assert property (@(posedge clk) disable iff (rst)
    (adv && s2_valid && (s2_cmd == CMD_BLEND) && !s2_ok)
      |=> (out_pixel == '0) && !out_wrote && (out_addr == '0))
    else $error("off-canvas blend produced a nonzero response");

endmodule
